// ----- rtl/wbps_pkg.sv -----
// Shared constants, types and helpers for the wildcard byte pattern search block.
`default_nettype none

package wbps_pkg;

	// Parameter defaults
	localparam int DEF_MAX_PATTERN  = 32;
	localparam int DEF_OFFSET_WIDTH = 32;

	// Configuration port geometry
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int PAT_WORDS  = 4;
	localparam int PAT_BYTES  = 32;
	localparam int WILD_W     = 32;
	localparam int LEN_W      = 6;
	localparam int LEN_CMP_W  = 7;
	localparam int OUT_OFS_W  = 32;

	localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_THIRD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WILD       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LEN        = 3'd5;

	typedef logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] pat_words_t;

	// One result word
	typedef struct packed {
		logic                 found;
		logic [OUT_OFS_W-1:0] match_offset;
	} out_word_t;

	// Pick pattern byte pos out of the four pattern words; positions past the
	// stored pattern read as zero
	function automatic logic [7:0] pattern_byte(input pat_words_t words, input int pos);
		logic [1:0] sel;
		logic [5:0] base;
		logic [7:0] res;
		sel  = pos[4:3];
		base = {pos[2:0], 3'b000};
		if (pos >= PAT_BYTES) begin
			res = 8'h00;
		end else begin
			res = words[sel][base +: 8];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/wbps_if.sv -----
// Stream channel interfaces: byte input and search result output.
`default_nettype none

interface wbps_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
	logic                           valid;
	logic                           ready;
	logic                           found;
	logic [wbps_pkg::OUT_OFS_W-1:0] match_offset;

	modport source (output valid, output found, output match_offset, input ready);
	modport sink (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

// ----- rtl/wbps_cell.sv -----
// One compare cell of the match chain: holds the partial-match bit of one position.
`default_nettype none

module wbps_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic       region_end,
	input  wire logic [7:0] data_byte,
	input  wire logic [7:0] pat_byte,
	input  wire logic       wild,
	input  wire logic       prev_match,
	output logic            hit,
	output logic            match_q
);

	// Extend the neighbor's partial match by this byte
	assign hit = prev_match && (wild || (data_byte == pat_byte));

	// Hold partial match until the next word; drop it at region end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (advance) begin
			match_q <= region_end ? 1'b0 : hit;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/wbps_obuf.sv -----
// Two-entry result buffer that decouples the scan chain from the result receiver.
`default_nettype none

module wbps_obuf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire wbps_pkg::out_word_t push_word,
	output logic                     has_room,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output wbps_pkg::out_word_t      out_word
);

	logic [1:0]          cnt_q;
	wbps_pkg::out_word_t slot0_q;
	wbps_pkg::out_word_t slot1_q;
	logic                pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_word  = slot0_q;
	assign has_room  = (cnt_q != 2'd2);
	assign pop       = out_valid && out_ready;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Advance slots on pop, fill the first free slot on push
	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && (cnt_q == 2'd1)) begin
				slot0_q <= push_word;
			end else begin
				slot0_q <= slot1_q;
			end
			if (push && (cnt_q == 2'd2)) begin
				slot1_q <= push_word;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				slot0_q <= push_word;
			end else begin
				slot1_q <= push_word;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/wildcard_byte_pattern_search.sv -----
// Top level: wildcard byte pattern search over a chain of per-position compare cells.
//
// Usage: bytes enter on the stream channel, one word per byte with a last_byte
// flag closing the region. The result channel carries at most one word per
// region: found with the start offset on the byte that completes the first
// match, or not-found with offset 0 on the region's last byte if nothing
// matched. Later matches in the same region are ignored.
// Throughput: one byte per cycle while the result buffer has room. Each byte
// updates every compare cell of the chain in the same cycle; cell k holds
// whether the last k+1 bytes match pattern positions 0..k, so no byte window
// has to be re-scanned. A result is registered into the result buffer when the
// byte that causes it is accepted, and is offered from there in order.
// Stall: a two-entry result buffer sits between the chain and the receiver;
// stream.ready drops only while both entries are occupied.
// Reset: arst_n clears the chain, byte count, reported flag, result buffer and
// registers (pattern 0, mask 0, length 1). The user writes the registers through
// cfg_we/cfg_idx/cfg_wdata only while no byte is in flight, unenforced by the block.
`default_nettype none

module wildcard_byte_pattern_search #(
	parameter int MAX_PATTERN  = wbps_pkg::DEF_MAX_PATTERN,
	parameter int OFFSET_WIDTH = wbps_pkg::DEF_OFFSET_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
	wbps_in_if.sink                              stream,
	wbps_out_if.source                           result
);

	localparam int IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int OFS_EXT = (OFFSET_WIDTH > wbps_pkg::OUT_OFS_W) ?
		OFFSET_WIDTH : wbps_pkg::OUT_OFS_W;
	localparam logic [OFFSET_WIDTH-1:0] COUNT_MAX = {OFFSET_WIDTH{1'b1}};

	// Configuration registers
	wbps_pkg::pat_words_t            pat_q;
	logic [wbps_pkg::WILD_W-1:0]     wild_q;
	logic [wbps_pkg::LEN_W-1:0]      len_q;

	// Region state
	logic [OFFSET_WIDTH-1:0]         cnt_q;
	logic                            reported_q;

	logic                            accept;
	logic                            last;
	logic [MAX_PATTERN-1:0]          hit;
	logic [MAX_PATTERN-1:0]          chain_q;
	logic [wbps_pkg::LEN_CMP_W-1:0]  len_wide;
	logic [wbps_pkg::LEN_CMP_W-1:0]  len_eff;
	logic [IDX_W-1:0]                len_m1;
	logic                            match_now;
	logic [OFFSET_WIDTH-1:0]         cnt_next;
	logic [OFFSET_WIDTH-1:0]         ofs_raw;
	logic [OFS_EXT-1:0]              ofs_ext;
	logic                            emit_found;
	logic                            emit_miss;
	logic                            push;
	wbps_pkg::out_word_t             push_word;
	wbps_pkg::out_word_t             out_word;
	logic                            has_room;

	assign accept = stream.valid && stream.ready;
	assign last   = stream.last_byte;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			wild_q <= '0;
			len_q  <= wbps_pkg::LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				wbps_pkg::REG_PAT_LOW:    pat_q[0] <= cfg_wdata;
				wbps_pkg::REG_PAT_SECOND: pat_q[1] <= cfg_wdata;
				wbps_pkg::REG_PAT_THIRD:  pat_q[2] <= cfg_wdata;
				wbps_pkg::REG_PAT_HIGH:   pat_q[3] <= cfg_wdata;
				wbps_pkg::REG_WILD:       wild_q <= cfg_wdata[wbps_pkg::WILD_W-1:0];
				wbps_pkg::REG_LEN:        len_q <= cfg_wdata[wbps_pkg::LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Compare chain: cell k sees the partial match of cell k-1 from the last byte
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic prev;
		logic wild;
		if (k == 0) begin : g_head
			assign prev = 1'b1;
		end else begin : g_link
			assign prev = chain_q[k-1];
		end
		if (k < wbps_pkg::WILD_W) begin : g_wild
			assign wild = wild_q[k];
		end else begin : g_fixed
			assign wild = 1'b0;
		end
		wbps_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.advance    (accept),
			.region_end (last),
			.data_byte  (stream.data_byte),
			.pat_byte   (wbps_pkg::pattern_byte(pat_q, k)),
			.wild       (wild),
			.prev_match (prev),
			.hit        (hit[k]),
			.match_q    (chain_q[k])
		);
	end

	// Clamp length and pick the full-length cell
	always_comb begin
		len_wide = {1'b0, len_q};
		if (len_wide > wbps_pkg::LEN_CMP_W'(MAX_PATTERN)) begin
			len_eff = wbps_pkg::LEN_CMP_W'(MAX_PATTERN);
		end else begin
			len_eff = len_wide;
		end
	end

	assign len_m1    = IDX_W'(len_eff - wbps_pkg::LEN_CMP_W'(1));
	assign match_now = (len_eff == '0) || hit[len_m1];

	// Saturating byte count and start offset
	assign cnt_next = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + OFFSET_WIDTH'(1);
	assign ofs_raw  = cnt_next - OFFSET_WIDTH'(len_eff);
	assign ofs_ext  = OFS_EXT'(ofs_raw);

	assign emit_found = !reported_q && match_now;
	assign emit_miss  = last && !reported_q && !match_now;
	assign push       = accept && (emit_found || emit_miss);

	// The empty pattern always reports offset 0
	always_comb begin
		push_word.found        = emit_found;
		push_word.match_offset = (emit_found && (len_eff != '0)) ?
			ofs_ext[wbps_pkg::OUT_OFS_W-1:0] : '0;
	end

	// Region count and reported flag; clear both at region end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				cnt_q      <= '0;
				reported_q <= 1'b0;
			end else begin
				cnt_q      <= cnt_next;
				reported_q <= reported_q || emit_found;
			end
		end
	end

	wbps_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.has_room  (has_room),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_word  (out_word)
	);

	assign stream.ready        = has_room;
	assign result.found        = out_word.found;
	assign result.match_offset = out_word.match_offset;

	// A full buffer always has a result on offer
	a_full_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!stream.ready |-> result.valid)
		else $error("input stalled with no result pending");

	// A found result on a non-final byte marks the region as reported
	a_found_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit_found && !last) |=> reported_q)
		else $error("found result did not mark the region");

	// Region end leaves count and flag clear
	a_region_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> ((cnt_q == '0) && !reported_q))
		else $error("region state not cleared after last byte");

	// No second result in a region once a match was reported
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && reported_q) |-> !push)
		else $error("second result in one region");

endmodule

`default_nettype wire

// ----- tb/sv/wbps_search_checker.sv -----
`timescale 1ns / 1ps
// Watches the byte and result channels, predicts each result word and compares it.
module wbps_search_checker
	import wbps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	wbps_in_if                    bytes_ch,
	wbps_out_if                   report_ch,
	output int                    fail_count,
	output int                    reports_due
);

	// Shadow copy of the registers
	logic [7:0]        pat [PAT_BYTES];
	logic [WILD_W-1:0] wild;
	logic [LEN_W-1:0]  plen;

	// Region state: newest byte at index 0
	logic [7:0]        window [PAT_BYTES];
	logic [31:0]       seen;
	logic              reported;

	out_word_t         reports_q [$];

	function automatic void clear_region();
		for (int i = 0; i < PAT_BYTES; i++) window[i] = 8'h00;
		seen = '0;
		reported = 1'b0;
	endfunction

	// Append one predicted result word
	function automatic void queue_report(out_word_t w);
		reports_q = {reports_q, w};
	endfunction

	// Position k of the pattern lines up with the byte len-1-k places back
	function automatic bit window_hit(int len);
		for (int k = 0; k < len; k++) begin
			if (!wild[k] && window[len - 1 - k] != pat[k]) return 1'b0;
		end
		return 1'b1;
	endfunction

	// Advance the region by one byte and queue the result word it causes
	function automatic void scan_byte(logic [7:0] b, logic last);
		int        len;
		bit        emitted;
		out_word_t r;
		len = plen;
		if (len > PAT_BYTES) len = PAT_BYTES;
		for (int i = PAT_BYTES - 1; i > 0; i--) window[i] = window[i - 1];
		window[0] = b;
		if (seen != 32'hFFFF_FFFF) seen = seen + 1;
		emitted = 1'b0;
		if (!reported) begin
			if (len == 0) begin
				r.found = 1'b1;
				r.match_offset = '0;
				queue_report(r);
				reported = 1'b1;
				emitted = 1'b1;
			end else if (seen >= len && window_hit(len)) begin
				r.found = 1'b1;
				r.match_offset = seen - len;
				queue_report(r);
				reported = 1'b1;
				emitted = 1'b1;
			end
		end
		// Report not-found at region end, then clear for the next region
		if (last) begin
			if (!emitted && !reported) begin
				r.found = 1'b0;
				r.match_offset = '0;
				queue_report(r);
			end
			clear_region();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		int        j;
		out_word_t want;
		if (!arst_n) begin
			for (j = 0; j < PAT_BYTES; j++) pat[j] = 8'h00;
			wild = '0;
			plen = LEN_RESET;
			clear_region();
			reports_q.delete();
			fail_count = 0;
			reports_due = 0;
		end else begin
			// Compare the result word against the oldest prediction
			if (report_ch.valid && report_ch.ready) begin
				if (reports_q.size() == 0) begin
					$error("unexpected result word: found %0b match_offset %0d",
						report_ch.found, report_ch.match_offset);
					fail_count++;
				end else begin
					want = reports_q.pop_front();
					if (report_ch.found !== want.found) begin
						$error("found: expected %0b, actual %0b", want.found, report_ch.found);
						fail_count++;
					end
					if (report_ch.match_offset !== want.match_offset) begin
						$error("match_offset: expected %0d, actual %0d",
							want.match_offset, report_ch.match_offset);
						fail_count++;
					end
				end
			end
			// Predict from the accepted byte word
			if (bytes_ch.valid && bytes_ch.ready) begin
				scan_byte(bytes_ch.data_byte, bytes_ch.last_byte);
			end
			// Track register writes
			if (cfg_we) begin
				case (cfg_idx)
				REG_PAT_LOW, REG_PAT_SECOND, REG_PAT_THIRD, REG_PAT_HIGH: begin
					for (j = 0; j < 8; j++) pat[int'(cfg_idx) * 8 + j] = cfg_wdata[8 * j +: 8];
				end
				REG_WILD: wild = cfg_wdata[WILD_W-1:0];
				REG_LEN: plen = cfg_wdata[LEN_W-1:0];
				default: ;
				endcase
			end
			reports_due = reports_q.size();
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, register setup, byte stimulus and verdict.
module testbench;
	import wbps_pkg::*;

	localparam int ITEM_TARGET    = 1550;
	localparam int PHASE_BYTES    = 110;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	wbps_in_if  bytes_ch ();
	wbps_out_if report_ch ();

	int fail_count;
	int reports_due;
	int bytes_sent;
	bit calm;
	bit hold_req;

	// Pattern currently loaded, kept for planting matches
	logic [7:0]        pat [PAT_BYTES];
	logic [WILD_W-1:0] wild;
	logic [LEN_W-1:0]  plen;

	wildcard_byte_pattern_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.stream    (bytes_ch),
		.result    (report_ch)
	);

	wbps_search_checker scan_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.bytes_ch    (bytes_ch),
		.report_ch   (report_ch),
		.fail_count  (fail_count),
		.reports_due (reports_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, one long hold-off on request
	initial begin : receiver
		int  hold_left;
		bit  hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		report_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				report_ch.ready <= 1'b0;
				hold_left--;
			end else if (calm) begin
				report_ch.ready <= 1'b1;
			end else begin
				report_ch.ready <= ($urandom_range(99) >= 31);
			end
		end
	end

	// End the run when neither channel moves a word for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((bytes_ch.valid && bytes_ch.ready) || (report_ch.valid && report_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	function automatic logic [7:0] alpha_byte();
		logic [7:0] v;
		case ($urandom_range(3))
		0: v = 8'h00;
		1: v = 8'hFF;
		2: v = 8'hA5;
		default: v = 8'h5A;
		endcase
		return v;
	endfunction

	// Filler bytes biased toward pattern content so near-misses occur
	function automatic logic [7:0] noise_byte();
		logic [7:0] v;
		case ($urandom_range(2))
		0: v = 8'($urandom_range(255));
		1: v = alpha_byte();
		default: v = pat[$urandom_range(PAT_BYTES - 1)];
		endcase
		return v;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pack_word(int w);
		logic [CFG_DATA_W-1:0] v;
		for (int j = 0; j < 8; j++) v[8 * j +: 8] = pat[8 * w + j];
		return v;
	endfunction

	// Offer one byte word with random gaps; return at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!calm && $urandom_range(99) < 31) begin
			bytes_ch.valid <= 1'b0;
			@(negedge clk);
		end
		bytes_ch.valid <= 1'b1;
		bytes_ch.data_byte <= b;
		bytes_ch.last_byte <= last;
		do @(posedge clk); while (!(bytes_ch.valid && bytes_ch.ready));
		@(negedge clk);
		bytes_sent++;
	endtask

	// Drain all predicted results, then give the block time to finish
	task automatic settle();
		bytes_ch.valid <= 1'b0;
		while (reports_due != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(negedge clk);
	endtask

	task automatic load_config();
		put_reg(REG_PAT_LOW, pack_word(0));
		put_reg(REG_PAT_SECOND, pack_word(1));
		put_reg(REG_PAT_THIRD, pack_word(2));
		put_reg(REG_PAT_HIGH, pack_word(3));
		put_reg(REG_WILD, CFG_DATA_W'(wild));
		put_reg(REG_LEN, CFG_DATA_W'(plen));
		cfg_we <= 1'b0;
	endtask

	// Choose the register setting for a phase; the first ones hit the extremes
	task automatic pick_config(input int phase);
		int r;
		case (phase)
		0: begin
			for (int i = 0; i < PAT_BYTES; i++) pat[i] = 8'hFF;
			wild = '0;
			plen = LEN_W'(32);
		end
		1: begin
			for (int i = 0; i < PAT_BYTES; i++) pat[i] = 8'h00;
			wild = '1;
			plen = LEN_W'(63);
		end
		2: begin
			for (int i = 0; i < PAT_BYTES; i++) pat[i] = 8'($urandom_range(255));
			wild = $urandom;
			plen = '0;
		end
		3: begin
			for (int i = 0; i < PAT_BYTES; i++) pat[i] = 8'($urandom_range(255));
			wild = '0;
			plen = LEN_W'(1);
		end
		4: begin
			for (int i = 0; i < PAT_BYTES; i++) pat[i] = alpha_byte();
			wild = $urandom & $urandom & $urandom;
			plen = LEN_W'(33);
		end
		default: begin
			for (int i = 0; i < PAT_BYTES; i++)
				pat[i] = $urandom_range(1) ? alpha_byte() : 8'($urandom_range(255));
			case ($urandom_range(3))
			0: wild = '0;
			1: wild = $urandom & $urandom;
			2: wild = WILD_W'(1) << $urandom_range(WILD_W - 1);
			default: wild = $urandom;
			endcase
			r = $urandom_range(99);
			if (r < 70) plen = LEN_W'($urandom_range(1, 6));
			else if (r < 90) plen = LEN_W'($urandom_range(7, 16));
			else plen = LEN_W'($urandom_range(17, 32));
		end
		endcase
	endtask

	// One region: mostly a planted match, some broken plants, short regions and noise
	task automatic send_random_region();
		int         eff, kind, rlen, at, broken, k;
		logic [7:0] b;
		eff = (plen > PAT_BYTES) ? PAT_BYTES : plen;
		kind = $urandom_range(99);
		at = -1;
		broken = -1;
		if (kind < 60) begin
			at = $urandom_range(10);
			rlen = at + eff + $urandom_range(8);
		end else if (kind < 72 && eff > 0) begin
			at = $urandom_range(10);
			rlen = at + eff + $urandom_range(8);
			broken = $urandom_range(eff - 1);
		end else if (kind < 85 && eff > 1) begin
			rlen = $urandom_range(1, eff - 1);
		end else if (kind < 88) begin
			at = $urandom_range(200, 300);
			rlen = at + eff + $urandom_range(4);
		end else begin
			rlen = $urandom_range(1, 30);
		end
		if (rlen < 1) rlen = 1;
		for (int i = 0; i < rlen; i++) begin
			k = i - at;
			if (at >= 0 && k >= 0 && k < eff) begin
				b = wild[k] ? 8'($urandom_range(255)) : pat[k];
				if (k == broken) b = pat[k] ^ (8'h01 << $urandom_range(7));
			end else begin
				b = noise_byte();
			end
			send_byte(b, i == rlen - 1);
		end
	endtask

	initial begin : stimulus
		int phase, budget;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		bytes_ch.valid = 1'b0;
		bytes_ch.data_byte = '0;
		bytes_ch.last_byte = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		bytes_sent = 0;
		for (int i = 0; i < PAT_BYTES; i++) pat[i] = 8'h00;
		wild = '0;
		plen = LEN_RESET;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset setting: one-byte pattern of zero
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);

		// Three positions, middle one wild: later matches, short region, match on last byte
		settle();
		pat[0] = 8'hAB;
		pat[1] = 8'hCD;
		pat[2] = 8'hEF;
		wild = WILD_W'(2);
		plen = LEN_W'(3);
		load_config();
		send_byte(8'hAB, 1'b0);
		send_byte(8'h77, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hAB, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hEF, 1'b1);
		send_byte(8'hAB, 1'b0);
		send_byte(8'h11, 1'b1);
		send_byte(8'h12, 1'b0);
		send_byte(8'hAB, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hEF, 1'b1);

		// Empty pattern matches at the first byte
		settle();
		plen = '0;
		load_config();
		send_byte(8'h5A, 1'b0);
		send_byte(8'h00, 1'b1);

		// Random phases, each under its own register setting
		phase = 0;
		while (bytes_sent < ITEM_TARGET) begin
			settle();
			if (phase == 5) begin
				// Stall the receiver while every one- or two-byte region reports a match
				for (int i = 0; i < PAT_BYTES; i++) pat[i] = 8'($urandom_range(255));
				wild = WILD_W'(1);
				plen = LEN_W'(1);
				load_config();
				hold_req = 1'b1;
				repeat (80) begin
					if ($urandom_range(1)) begin
						send_byte(noise_byte(), 1'b1);
					end else begin
						send_byte(noise_byte(), 1'b0);
						send_byte(noise_byte(), 1'b1);
					end
				end
			end else begin
				pick_config(phase);
				load_config();
				calm = (phase == 8);
				budget = bytes_sent + PHASE_BYTES;
				while (bytes_sent < budget) send_random_region();
				calm = 1'b0;
			end
			phase++;
		end

		settle();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/wbps_pkg.sv
rtl/wbps_if.sv
rtl/wbps_cell.sv
rtl/wbps_obuf.sv
rtl/wildcard_byte_pattern_search.sv
tb/sv/wbps_search_checker.sv
tb/sv/testbench.sv
